// File: src/fpws_pkg.sv
// fpws_pkg: shared types and constants of the frame pacer with window stats
// no dependencies; used by fpws_div and frame_pacer_with_window_stats_unit
`default_nettype none

package fpws_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned RATE_W   = 20;
  localparam int unsigned WCOUNT_W = 7;

  // dividend of the period division, one second in ns, fits 30 bits
  localparam int unsigned DIV_W = 30;
  localparam logic [DIV_W-1:0] NS_PER_SEC = 30'd1000000000;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd60;

  localparam int unsigned HISTORY_DEPTH_DEF = 64;
  localparam int unsigned LAG_PERIODS_DEF   = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LAG,
    ST_NOW,
    ST_UPD,
    ST_WR,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// File: src/fpws_ram.sv
// fpws_ram: generic simple dual port ram, one write and one read port
// registered read data, no reset on the array; no dependencies
`default_nettype none

module fpws_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/fpws_div.sv
// fpws_div: restoring divider for the frame period, one quotient bit per cycle
// depends on fpws_pkg (NS_PER_SEC, DIV_W, RATE_W)
`default_nettype none

module fpws_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [fpws_pkg::RATE_W-1:0] divisor_i,
  output logic                             done_o,
  output logic      [fpws_pkg::DIV_W-1:0]  quot_o
);

  localparam int unsigned RW    = fpws_pkg::RATE_W;
  localparam int unsigned QW    = fpws_pkg::DIV_W;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW:0]     rem_q;
  logic [QW-1:0]   dq_q;
  logic [RW-1:0]   dvs_q;

  logic [RW:0]     rem_sh;
  logic [RW+1:0]   trial;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q[RW-1:0], dq_q[QW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
    fits   = ~trial[RW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= fpws_pkg::NS_PER_SEC;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[RW:0] : rem_sh;
      dq_q  <= {dq_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

`default_nettype wire

// File: src/frame_pacer_with_window_stats_unit.sv
// frame pacer: an input transfer starts the period divider and the window sweep together; the
// result loads in ST_FIN after ST_LAG, ST_NOW, ST_UPD and ST_WR, once the sweep has finished
// one frame at a time, the next frame is taken the cycle after the result loads; the window
// sweep reads one history ram entry per cycle beside the period divider, and a result
// stalled at the output holds the next frame back
// reset clears all pacing state and counters at once; the history ram needs no clear
`default_nettype none

module frame_pacer_with_window_stats_unit #(
  parameter int unsigned HISTORY_DEPTH = fpws_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned LAG_PERIODS   = fpws_pkg::LAG_PERIODS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          target_rate_we_i,
  input  wire logic [fpws_pkg::RATE_W-1:0]   target_rate_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [fpws_pkg::TIME_W-1:0]   arrival_ns_i,
  input  wire logic [fpws_pkg::TIME_W-1:0]   after_wait_ns_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [fpws_pkg::TIME_W-1:0]   wait_ns_o,
  output logic      [fpws_pkg::TIME_W-1:0]   elapsed_ns_o,
  output logic      [fpws_pkg::TIME_W-1:0]   frames_total_o,
  output logic      [fpws_pkg::TIME_W-1:0]   total_time_ns_o,
  output logic      [fpws_pkg::WCOUNT_W-1:0] window_count_o,
  output logic      [fpws_pkg::TIME_W-1:0]   window_sum_ns_o,
  output logic      [fpws_pkg::TIME_W-1:0]   window_shortest_ns_o,
  output logic      [fpws_pkg::TIME_W-1:0]   window_longest_ns_o
);

  localparam int unsigned TW     = fpws_pkg::TIME_W;
  localparam int unsigned RW     = fpws_pkg::RATE_W;
  localparam int unsigned PW     = fpws_pkg::DIV_W;
  localparam int unsigned CW     = fpws_pkg::WCOUNT_W;
  localparam int unsigned ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LAGM_W = $clog2(LAG_PERIODS + 1);
  localparam int unsigned LAG_W  = PW + LAGM_W;

  fpws_pkg::state_e state_q, state_d;

  // configuration and pacing state
  logic [RW-1:0]     rate_q;
  logic              started_q;
  logic [TW-1:0]     last_time_q;
  logic [TW-1:0]     deadline_q;
  logic [ADDR_W-1:0] slot_q;
  logic [CNT_W-1:0]  fill_q;
  logic [TW-1:0]     frame_cnt_q;
  logic [TW-1:0]     time_sum_q;

  // per-frame working registers
  logic [TW-1:0]     arrival_q;
  logic [TW-1:0]     after_q;
  logic [PW-1:0]     period_q;
  logic [LAG_W-1:0]  lag_q;
  logic              late_q;
  logic [TW-1:0]     wait_q;
  logic [TW-1:0]     now_q;
  logic [TW-1:0]     diff_q;
  logic              ahead_q;
  logic [TW-1:0]     eld_q;
  logic              back_q;
  logic [TW-1:0]     elapsed_q;

  // window sweep
  logic [CNT_W-1:0]  sw_idx_q;
  logic [CNT_W-1:0]  sw_n_q;
  logic [ADDR_W-1:0] skip_slot_q;
  logic              rd_pend_q;
  logic              rd_skip_q;
  logic [TW-1:0]     wsum_q;
  logic [TW-1:0]     wmin_q;
  logic [TW-1:0]     wmax_q;

  logic              out_valid_q;

  logic              in_xfer;
  logic              out_load;
  logic              div_done;
  logic [PW-1:0]     div_quot;
  logic [RW-1:0]     divisor;
  logic              sw_rd;
  logic              sw_done;
  logic [TW-1:0]     rd_data;
  logic [CNT_W-1:0]  fill_next;

  assign in_xfer   = in_valid_i & in_ready_o;
  assign divisor   = (rate_q == '0) ? RW'(1) : rate_q;
  assign sw_rd     = sw_idx_q < sw_n_q;
  assign sw_done   = ~sw_rd & ~rd_pend_q;
  assign fill_next = (fill_q < CNT_W'(HISTORY_DEPTH)) ? fill_q + 1'b1 : fill_q;

  fpws_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_xfer),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  fpws_ram #(
    .WIDTH (TW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (state_q == fpws_pkg::ST_WR),
    .waddr_i (slot_q),
    .wdata_i (elapsed_q),
    .re_i    (sw_rd),
    .raddr_i (sw_idx_q[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      fpws_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = fpws_pkg::ST_DIV;
        end
      end
      fpws_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = fpws_pkg::ST_LAG;
        end
      end
      fpws_pkg::ST_LAG: state_d = fpws_pkg::ST_NOW;
      fpws_pkg::ST_NOW: state_d = fpws_pkg::ST_UPD;
      fpws_pkg::ST_UPD: state_d = fpws_pkg::ST_WR;
      fpws_pkg::ST_WR:  state_d = fpws_pkg::ST_FIN;
      fpws_pkg::ST_FIN: begin
        if (sw_done && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          state_d  = fpws_pkg::ST_IDLE;
        end
      end
      default: state_d = fpws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= fpws_pkg::RATE_RESET;
    end else if (target_rate_we_i) begin
      rate_q <= target_rate_i;
    end
  end

  // ------------------------------------------------------------ pacing path
  logic [TW:0]   sub_dl;
  logic [TW:0]   sub_last;
  logic [TW-1:0] now_c;
  logic          rearm;
  logic [TW-1:0] dl_base;
  logic [TW:0]   dl_sum;
  logic [TW-1:0] period_w;

  always_comb begin
    period_w = TW'(period_q);
    now_c    = late_q ? after_q : arrival_q;
    sub_dl   = {1'b0, now_c} - {1'b0, deadline_q};
    sub_last = {1'b0, now_c} - {1'b0, last_time_q};
    rearm    = ahead_q && (diff_q >= TW'(lag_q));
    dl_base  = (!started_q || rearm) ? now_q : deadline_q;
    dl_sum   = {1'b0, dl_base} + {1'b0, period_w};
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      arrival_q <= arrival_ns_i;
      after_q   <= after_wait_ns_i;
    end
    if (state_q == fpws_pkg::ST_DIV && div_done) begin
      period_q <= (div_quot == '0) ? PW'(1) : div_quot;
    end
    if (state_q == fpws_pkg::ST_LAG) begin
      lag_q  <= LAG_W'(period_q) * LAG_W'(LAG_PERIODS);
      late_q <= started_q && (arrival_q < deadline_q);
      wait_q <= (started_q && (arrival_q < deadline_q)) ? deadline_q - arrival_q : '0;
    end
    if (state_q == fpws_pkg::ST_NOW) begin
      now_q   <= now_c;
      diff_q  <= sub_dl[TW-1:0];
      ahead_q <= ~sub_dl[TW] && (sub_dl[TW-1:0] != '0);
      eld_q   <= sub_last[TW-1:0];
      back_q  <= sub_last[TW];
    end
    if (state_q == fpws_pkg::ST_UPD) begin
      if (!started_q || back_q) begin
        elapsed_q <= period_w;
      end else if (eld_q == '0) begin
        elapsed_q <= TW'(1);
      end else begin
        elapsed_q <= eld_q;
      end
    end
  end

  logic [TW:0] tsum_add;
  assign tsum_add = {1'b0, time_sum_q} + {1'b0, elapsed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      last_time_q <= '0;
      deadline_q  <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      frame_cnt_q <= '0;
      time_sum_q  <= '0;
    end else begin
      if (state_q == fpws_pkg::ST_UPD) begin
        started_q   <= 1'b1;
        last_time_q <= now_q;
        deadline_q  <= dl_sum[TW] ? '1 : dl_sum[TW-1:0];
      end
      if (state_q == fpws_pkg::ST_WR) begin
        slot_q      <= (slot_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        fill_q      <= fill_next;
        frame_cnt_q <= (&frame_cnt_q) ? frame_cnt_q : frame_cnt_q + 1'b1;
        time_sum_q  <= tsum_add[TW] ? '1 : tsum_add[TW-1:0];
      end
    end
  end

  // ------------------------------------------------------------ window sweep
  // walks every window entry except the slot being overwritten, next to the divider
  logic [TW:0] wsum_add;
  assign wsum_add = {1'b0, wsum_q} + {1'b0, rd_data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_idx_q  <= '0;
      sw_n_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= sw_rd;
      if (in_xfer) begin
        sw_idx_q <= '0;
        sw_n_q   <= fill_next;
      end else if (sw_rd) begin
        sw_idx_q <= sw_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_skip_q <= sw_idx_q[ADDR_W-1:0] == skip_slot_q;
    if (in_xfer) begin
      skip_slot_q <= slot_q;
      wsum_q      <= '0;
      wmin_q      <= '1;
      wmax_q      <= '0;
    end else if (rd_pend_q && !rd_skip_q) begin
      wsum_q <= wsum_add[TW] ? '1 : wsum_add[TW-1:0];
      if (rd_data < wmin_q) begin
        wmin_q <= rd_data;
      end
      if (rd_data > wmax_q) begin
        wmax_q <= rd_data;
      end
    end
  end

  // ------------------------------------------------------------ result stage
  logic [TW:0]      fsum_add;
  logic [CNT_W+CW-1:0] fill_wide;
  assign fsum_add  = {1'b0, wsum_q} + {1'b0, elapsed_q};
  assign fill_wide = {{CW{1'b0}}, fill_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      wait_ns_o            <= wait_q;
      elapsed_ns_o         <= elapsed_q;
      frames_total_o       <= frame_cnt_q;
      total_time_ns_o      <= time_sum_q;
      window_count_o       <= fill_wide[CW-1:0];
      window_sum_ns_o      <= fsum_add[TW] ? '1 : fsum_add[TW-1:0];
      window_shortest_ns_o <= (elapsed_q < wmin_q) ? elapsed_q : wmin_q;
      window_longest_ns_o  <= (elapsed_q > wmax_q) ? elapsed_q : wmax_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_elapsed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> elapsed_ns_o != '0)
    else $error("result frame time is zero");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_shortest_ns_o <= window_longest_ns_o)
    else $error("window shortest above longest");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(HISTORY_DEPTH))
    else $error("window fill count beyond depth");

  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == fpws_pkg::ST_DIV && !in_ready_o)
    else $error("second frame taken while one is in flight");
`endif

endmodule

`default_nettype wire

// File: verif/tb_frame_pacer_with_window_stats_unit.sv
// testbench for frame_pacer_with_window_stats_unit: frame calls go in, one pacing result each
// depends on fpws_pkg and the unit; a scoreboard class predicts each result and checks it
module tb_frame_pacer_with_window_stats_unit;
  import fpws_pkg::*;

  localparam int unsigned WIN_DEPTH   = HISTORY_DEPTH_DEF;
  localparam int unsigned LAG_COUNT   = LAG_PERIODS_DEF;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned END_CYCLES  = 80;

  typedef logic [TIME_W-1:0] ns_t;

  typedef struct packed {
    ns_t                 wait_ns;
    ns_t                 elapsed_ns;
    ns_t                 frames_total;
    ns_t                 total_time_ns;
    logic [WCOUNT_W-1:0] window_count;
    ns_t                 window_sum_ns;
    ns_t                 window_shortest_ns;
    ns_t                 window_longest_ns;
  } pacing_result_t;

  class pacer_scoreboard;
    logic [RATE_W-1:0] rate;
    bit                started;
    ns_t               last_ns;
    ns_t               deadline_ns;
    ns_t               frames;
    ns_t               time_total;
    ns_t               ring [WIN_DEPTH];
    int unsigned       slot;
    int unsigned       fill;
    int unsigned       results_seen;
    int unsigned       errors;
    pacing_result_t    expected_q [$];

    function new();
      rate         = RATE_RESET;
      started      = 1'b0;
      last_ns      = '0;
      deadline_ns  = '0;
      frames       = '0;
      time_total   = '0;
      slot         = 0;
      fill         = 0;
      results_seen = 0;
      errors       = 0;
    endfunction

    static function ns_t sat_add(ns_t a, ns_t b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function ns_t period_ns();
      ns_t r;
      ns_t p;
      r = (rate == 0) ? ns_t'(1) : ns_t'(rate);
      p = ns_t'(NS_PER_SEC) / r;
      return (p == 0) ? ns_t'(1) : p;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // called at the edge where a frame transfer happens
    function void note_frame(ns_t arrival, ns_t after_wait);
      ns_t            per;
      ns_t            lag;
      ns_t            now;
      ns_t            elapsed;
      ns_t            wsum;
      ns_t            wmin;
      ns_t            wmax;
      pacing_result_t r;
      per = period_ns();
      r.wait_ns = '0;
      if (!started) begin
        started     = 1'b1;
        last_ns     = arrival;
        deadline_ns = sat_add(arrival, per);
        elapsed     = per;
      end else begin
        // period is at most one second, so ten periods never overflow
        lag = per * LAG_COUNT;
        now = arrival;
        if (arrival < deadline_ns) begin
          r.wait_ns = deadline_ns - arrival;
          now       = after_wait;
        end
        if (now > deadline_ns && now - deadline_ns >= lag) begin
          deadline_ns = sat_add(now, per);
        end else begin
          deadline_ns = sat_add(deadline_ns, per);
        end
        elapsed = (now >= last_ns) ? now - last_ns : per;
        if (elapsed == 0) begin
          elapsed = ns_t'(1);
        end
        last_ns = now;
      end
      frames     = sat_add(frames, ns_t'(1));
      time_total = sat_add(time_total, elapsed);
      ring[slot] = elapsed;
      slot       = (slot + 1) % WIN_DEPTH;
      if (fill < WIN_DEPTH) begin
        fill++;
      end
      wsum = '0;
      wmin = '1;
      wmax = '0;
      for (int i = 0; i < fill; i++) begin
        wsum = sat_add(wsum, ring[i]);
        if (ring[i] < wmin) wmin = ring[i];
        if (ring[i] > wmax) wmax = ring[i];
      end
      r.elapsed_ns         = elapsed;
      r.frames_total       = frames;
      r.total_time_ns      = time_total;
      r.window_count       = fill[WCOUNT_W-1:0];
      r.window_sum_ns      = wsum;
      r.window_shortest_ns = wmin;
      r.window_longest_ns  = wmax;
      expected_q.push_back(r);
    endfunction

    task check_field(string name, ns_t got, ns_t want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
      end
    endtask

    task check_result(pacing_result_t got);
      pacing_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no frame outstanding", results_seen));
      end else begin
        want = expected_q.pop_front();
        check_field("wait_ns", got.wait_ns, want.wait_ns);
        check_field("elapsed_ns", got.elapsed_ns, want.elapsed_ns);
        check_field("frames_total", got.frames_total, want.frames_total);
        check_field("total_time_ns", got.total_time_ns, want.total_time_ns);
        check_field("window_count", ns_t'(got.window_count), ns_t'(want.window_count));
        check_field("window_sum_ns", got.window_sum_ns, want.window_sum_ns);
        check_field("window_shortest_ns", got.window_shortest_ns, want.window_shortest_ns);
        check_field("window_longest_ns", got.window_longest_ns, want.window_longest_ns);
      end
      results_seen++;
    endtask
  endclass

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                target_rate_we_i = 1'b0;
  logic [RATE_W-1:0]   target_rate_i    = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  ns_t                 arrival_ns_i     = '0;
  ns_t                 after_wait_ns_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  ns_t                 wait_ns_o;
  ns_t                 elapsed_ns_o;
  ns_t                 frames_total_o;
  ns_t                 total_time_ns_o;
  logic [WCOUNT_W-1:0] window_count_o;
  ns_t                 window_sum_ns_o;
  ns_t                 window_shortest_ns_o;
  ns_t                 window_longest_ns_o;

  pacer_scoreboard board;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  bit              hold_request   = 1'b0;
  int unsigned     hold_left      = 0;
  int unsigned     quiet_cycles   = 0;

  frame_pacer_with_window_stats_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .target_rate_we_i     (target_rate_we_i),
    .target_rate_i        (target_rate_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .arrival_ns_i         (arrival_ns_i),
    .after_wait_ns_i      (after_wait_ns_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .wait_ns_o            (wait_ns_o),
    .elapsed_ns_o         (elapsed_ns_o),
    .frames_total_o       (frames_total_o),
    .total_time_ns_o      (total_time_ns_o),
    .window_count_o       (window_count_o),
    .window_sum_ns_o      (window_sum_ns_o),
    .window_shortest_ns_o (window_shortest_ns_o),
    .window_longest_ns_o  (window_longest_ns_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // result side: check on transfer, then pick ready for the next cycle
  always @(posedge clk_i) begin : result_side
    pacing_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      // packed in field order
      got = {wait_ns_o, elapsed_ns_o, frames_total_o, total_time_ns_o, window_count_o,
             window_sum_ns_o, window_shortest_ns_o, window_longest_ns_o};
      board.check_result(got);
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[frame_pacer_with_window_stats_unit] ERROR");
      $finish;
    end
  end

  // valid is lowered here only when this frame starts with an idle cycle; wait_drained lowers it too
  task automatic send_frame(input ns_t arrival, input ns_t after_wait);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    arrival_ns_i    <= arrival;
    after_wait_ns_i <= after_wait;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_frame(arrival, after_wait);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    target_rate_we_i <= 1'b1;
    target_rate_i    <= value;
    @(posedge clk_i);
    board.rate = value;
    target_rate_we_i <= 1'b0;
  endtask

  // mostly a paced loop around the current deadline, plus lag, rewind, same-time and raw noise
  task automatic random_frame();
    ns_t         per;
    ns_t         dl;
    ns_t         arrival;
    ns_t         after_wait;
    int unsigned kind;
    per  = board.period_ns();
    dl   = board.deadline_ns;
    kind = $urandom_range(99);
    if (kind < 40) begin
      arrival    = dl - ns_t'($urandom_range(32'(per), 0));
      after_wait = dl + ns_t'($urandom_range(32'(per / 8), 0));
    end else if (kind < 70) begin
      arrival    = dl + ns_t'($urandom_range(32'(per * 2), 0));
      after_wait = {$urandom, $urandom};
    end else if (kind < 80) begin
      arrival    = dl + per * ns_t'($urandom_range(40, 9));
      after_wait = {$urandom, $urandom};
    end else if (kind < 88) begin
      arrival    = board.last_ns - ns_t'($urandom_range(32'(per), 1));
      after_wait = arrival;
    end else if (kind < 94) begin
      // same time as the last frame gives a zero difference, which the frame time clamps to one
      arrival    = board.last_ns;
      after_wait = board.last_ns;
    end else begin
      arrival    = {$urandom, $urandom};
      after_wait = {$urandom, $urandom};
    end
    send_frame(arrival, after_wait);
  endtask

  initial begin
    logic [RATE_W-1:0] phase_rate [5];
    int unsigned       phase_send [5];
    int unsigned       phase_recv [5];
    int unsigned       phase_len  [5];
    ns_t               per;
    board = new();
    phase_rate = '{20'd1, '1, 20'd0, 20'd1000000, RATE_W'($urandom_range(999999, 2))};
    phase_send = '{0, 75, 0, 24, 0};
    phase_recv = '{0, 0, 75, 24, 0};
    phase_len  = '{120, 120, 120, 120, 40};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at the reset rate
    per = board.period_ns();
    send_frame('0, '1);
    send_frame(64'd1000, per);
    send_frame(board.deadline_ns + 5, '1);
    send_frame(board.deadline_ns + per * LAG_COUNT, '0);
    send_frame(board.deadline_ns + per * LAG_COUNT - 1, '0);
    send_frame(64'd5, 64'd3);
    send_frame(board.last_ns, board.last_ns);
    send_frame('1, '0);
    send_frame('1, '1);
    send_frame('0, '0);
    send_frame('0, '1);
    send_frame(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_frame(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

    for (int ph = 0; ph < 5; ph++) begin
      write_rate(phase_rate[ph]);
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      for (int n = 0; n < phase_len[ph]; n++) begin
        if (ph == 2 && n == 10) begin
          hold_request = 1'b1;
        end
        random_frame();
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("[frame_pacer_with_window_stats_unit] OK");
    end else begin
      $display("[frame_pacer_with_window_stats_unit] ERROR");
    end
    $finish;
  end

endmodule
